// File: rtl/lrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrs_pkg;

  localparam int unsigned POLL_INTERVAL_MS = 100;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [TIME_W-1:0] ms_t;

  typedef enum logic [1:0] {
    MODE_POLL   = 2'd0,
    MODE_BEGIN  = 2'd1,
    MODE_MANUAL = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_STORED      = 3'd1,
    ACT_PROVISIONED = 3'd2,
    ACT_MANUAL      = 3'd3,
    ACT_LISTEN      = 3'd4,
    ACT_DROP        = 3'd5,
    ACT_OFF         = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    MAN_IDLE    = 2'd0,
    MAN_PENDING = 2'd1,
    MAN_OK      = 2'd2,
    MAN_FAILED  = 2'd3
  } manual_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HAS_STORED_CREDS    = 3'd0,
    CFG_PROVISIONED_AT_BOOT = 3'd1,
    CFG_PHASE_COUNT         = 3'd2,
    CFG_CONNECT_TIMEOUT     = 3'd3,
    CFG_RETRY_INTERVAL      = 3'd4,
    CFG_ATTEMPTS_BEFORE     = 3'd5,
    CFG_LISTEN_TIMEOUT      = 3'd6,
    CFG_PHASE_LENGTH        = 3'd7
  } cfg_idx_t;

endpackage

`default_nettype wire

// File: rtl/link_reconnect_supervisor_top.sv
// Link reconnect supervisor. Each request (poll, begin or manual connect, with a
// wrapping millisecond timestamp and the radio's link-up and provisioning-done
// flags) yields exactly one result: link state, radio action, listen phase,
// manual-connect status, failed-attempt count, provisioned flag and a one-result
// persist pulse. A new request is accepted every cycle unless the result
// register is held by out_stall; each request passes through the input
// register and then the result register. The supervisor state is updated as a
// request moves from the input register into the result register. Write the
// configuration registers only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module link_reconnect_supervisor_top #(
  parameter int unsigned POLL_INTERVAL_MS = lrs_pkg::POLL_INTERVAL_MS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic [31:0]                    in_now_ms,
  input  logic                           in_link_up,
  input  logic                           in_provisioning_done,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_link_state,
  output logic [2:0]                     out_radio_action,
  output logic [1:0]                     out_listen_phase,
  output logic [1:0]                     out_manual_status,
  output logic [7:0]                     out_failed_attempts,
  output logic                           out_provisioned,
  output logic                           out_persist_provisioned,
  input  logic                           cfg_wr_en,
  input  logic [lrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  import lrs_pkg::*;

  typedef enum logic [2:0] {
    ST_OFF          = 3'd0,
    ST_CONNECTING   = 3'd1,
    ST_CONNECTED    = 3'd2,
    ST_RETRY        = 3'd3,
    ST_PROVISIONING = 3'd4
  } state_t;

  localparam ms_t POLL_MS = ms_t'(POLL_INTERVAL_MS);

  // configuration
  logic       has_stored_r;
  logic       prov_boot_r;
  logic [1:0] phase_count_r;
  ms_t        connect_to_r;
  ms_t        retry_int_r;
  logic [7:0] attempts_lim_r;
  ms_t        listen_to_r;
  ms_t        phase_len_r;

  // input register
  logic       s1_valid_r;
  mode_t      s1_mode_r;
  ms_t        s1_now_r;
  logic       s1_up_r;
  logic       s1_done_r;

  // supervisor state
  logic       started_r, started_nxt;
  state_t     state_r, state_nxt;
  ms_t        entry_r, entry_nxt;
  ms_t        last_poll_r, last_poll_nxt;
  ms_t        listen_start_r, listen_start_nxt;
  ms_t        phase_start_r, phase_start_nxt;
  logic [1:0] phase_idx_r, phase_idx_nxt;
  logic [7:0] attempts_r, attempts_nxt;
  logic       prov_flag_r, prov_flag_nxt;
  logic       prefer_prov_r, prefer_prov_nxt;
  manual_t    manual_r, manual_nxt;
  action_t    action_nxt;
  logic       persist_nxt;

  // result register
  logic       out_valid_r;
  state_t     out_state_r;
  action_t    out_action_r;
  logic [1:0] out_phase_r;
  manual_t    out_manual_r;
  logic [7:0] out_attempts_r;
  logic       out_prov_r;
  logic       out_persist_r;

  logic       advance;
  logic       fire;
  logic [7:0] att_inc;
  logic [2:0] phase_sum;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    started_nxt      = started_r;
    state_nxt        = state_r;
    entry_nxt        = entry_r;
    last_poll_nxt    = last_poll_r;
    listen_start_nxt = listen_start_r;
    phase_start_nxt  = phase_start_r;
    phase_idx_nxt    = phase_idx_r;
    attempts_nxt     = attempts_r;
    prov_flag_nxt    = prov_flag_r;
    prefer_prov_nxt  = prefer_prov_r;
    manual_nxt       = manual_r;
    action_nxt       = ACT_NONE;
    persist_nxt      = 1'b0;
    att_inc          = (attempts_r != 8'hFF) ? attempts_r + 8'd1 : attempts_r;
    phase_sum        = {1'b0, phase_idx_r} + 3'd1;

    case (s1_mode_r)
      MODE_POLL: begin
        if (started_r && (ms_t'(s1_now_r - last_poll_r) >= POLL_MS)) begin
          last_poll_nxt = s1_now_r;
          case (state_r)
            ST_CONNECTING: begin
              if (s1_up_r) begin
                attempts_nxt = 8'd0;
                if (manual_r == MAN_PENDING) begin
                  manual_nxt      = MAN_OK;
                  prov_flag_nxt   = 1'b1;
                  prefer_prov_nxt = 1'b1;
                  persist_nxt     = 1'b1;
                end
                state_nxt = ST_CONNECTED;
                entry_nxt = s1_now_r;
              end else if (ms_t'(s1_now_r - entry_r) >= connect_to_r) begin
                attempts_nxt = att_inc;
                action_nxt   = ACT_DROP;
                if (manual_r == MAN_PENDING) begin
                  manual_nxt = MAN_FAILED;
                  state_nxt  = ST_RETRY;
                  entry_nxt  = s1_now_r;
                end else if (att_inc >= attempts_lim_r) begin
                  attempts_nxt     = 8'd0;
                  phase_idx_nxt    = 2'd0;
                  listen_start_nxt = s1_now_r;
                  phase_start_nxt  = s1_now_r;
                  action_nxt       = ACT_LISTEN;
                  state_nxt        = ST_PROVISIONING;
                  entry_nxt        = s1_now_r;
                end else begin
                  if (has_stored_r && prov_flag_r) begin
                    prefer_prov_nxt = !prefer_prov_r;
                  end
                  state_nxt = ST_RETRY;
                  entry_nxt = s1_now_r;
                end
              end
            end
            ST_CONNECTED: begin
              if (!s1_up_r) begin
                state_nxt = ST_RETRY;
                entry_nxt = s1_now_r;
              end
            end
            ST_RETRY: begin
              if (ms_t'(s1_now_r - entry_r) >= retry_int_r) begin
                action_nxt = (prefer_prov_r && prov_flag_r) ? ACT_PROVISIONED : ACT_STORED;
                state_nxt  = ST_CONNECTING;
                entry_nxt  = s1_now_r;
              end
            end
            ST_PROVISIONING: begin
              if (s1_done_r && s1_up_r) begin
                prov_flag_nxt   = 1'b1;
                prefer_prov_nxt = 1'b1;
                persist_nxt     = 1'b1;
                attempts_nxt    = 8'd0;
                state_nxt       = ST_CONNECTED;
                entry_nxt       = s1_now_r;
              end else if (ms_t'(s1_now_r - listen_start_r) >= listen_to_r) begin
                if (has_stored_r || prov_flag_r) begin
                  state_nxt = ST_RETRY;
                end else begin
                  action_nxt = ACT_OFF;
                  state_nxt  = ST_OFF;
                end
                entry_nxt = s1_now_r;
              end else if (ms_t'(s1_now_r - phase_start_r) >= phase_len_r) begin
                case (phase_count_r)
                  2'd2:    phase_idx_nxt = {1'b0, phase_sum[0]};
                  2'd3:    phase_idx_nxt = (phase_sum == 3'd3) ? 2'd0 : phase_sum[1:0];
                  default: phase_idx_nxt = 2'd0;
                endcase
                phase_start_nxt = s1_now_r;
                action_nxt      = ACT_LISTEN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      MODE_BEGIN: begin
        if (!started_r) begin
          started_nxt   = 1'b1;
          prov_flag_nxt = prov_boot_r;
        end
        if (!has_stored_r && !prov_flag_nxt) begin
          phase_idx_nxt    = 2'd0;
          listen_start_nxt = s1_now_r;
          phase_start_nxt  = s1_now_r;
          action_nxt       = ACT_LISTEN;
          state_nxt        = ST_PROVISIONING;
        end else begin
          prefer_prov_nxt = prov_flag_nxt;
          action_nxt      = prov_flag_nxt ? ACT_PROVISIONED : ACT_STORED;
          state_nxt       = ST_CONNECTING;
        end
        entry_nxt = s1_now_r;
      end
      MODE_MANUAL: begin
        if (!started_r) begin
          started_nxt   = 1'b1;
          prov_flag_nxt = prov_boot_r;
        end
        manual_nxt   = MAN_PENDING;
        attempts_nxt = 8'd0;
        action_nxt   = ACT_MANUAL;
        state_nxt    = ST_CONNECTING;
        entry_nxt    = s1_now_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_stored_r   <= 1'b1;
      prov_boot_r    <= 1'b0;
      phase_count_r  <= 2'd2;
      connect_to_r   <= ms_t'(15000);
      retry_int_r    <= ms_t'(30000);
      attempts_lim_r <= 8'd3;
      listen_to_r    <= ms_t'(120000);
      phase_len_r    <= ms_t'(20000);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HAS_STORED_CREDS:    has_stored_r   <= cfg_data[0];
        CFG_PROVISIONED_AT_BOOT: prov_boot_r    <= cfg_data[0];
        CFG_PHASE_COUNT:         phase_count_r  <= cfg_data[1:0];
        CFG_CONNECT_TIMEOUT:     connect_to_r   <= cfg_data;
        CFG_RETRY_INTERVAL:      retry_int_r    <= cfg_data;
        CFG_ATTEMPTS_BEFORE:     attempts_lim_r <= cfg_data[7:0];
        CFG_LISTEN_TIMEOUT:      listen_to_r    <= cfg_data;
        CFG_PHASE_LENGTH:        phase_len_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_mode_r <= mode_t'(in_mode);
      s1_now_r  <= in_now_ms;
      s1_up_r   <= in_link_up;
      s1_done_r <= in_provisioning_done;
    end
    if (fire) begin
      out_state_r    <= state_nxt;
      out_action_r   <= action_nxt;
      out_phase_r    <= phase_idx_nxt;
      out_manual_r   <= manual_nxt;
      out_attempts_r <= attempts_nxt;
      out_prov_r     <= prov_flag_nxt;
      out_persist_r  <= persist_nxt;
    end
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      started_r      <= 1'b0;
      state_r        <= ST_OFF;
      entry_r        <= '0;
      last_poll_r    <= '0;
      listen_start_r <= '0;
      phase_start_r  <= '0;
      phase_idx_r    <= 2'd0;
      attempts_r     <= 8'd0;
      prov_flag_r    <= 1'b0;
      prefer_prov_r  <= 1'b0;
      manual_r       <= MAN_IDLE;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        started_r      <= started_nxt;
        state_r        <= state_nxt;
        entry_r        <= entry_nxt;
        last_poll_r    <= last_poll_nxt;
        listen_start_r <= listen_start_nxt;
        phase_start_r  <= phase_start_nxt;
        phase_idx_r    <= phase_idx_nxt;
        attempts_r     <= attempts_nxt;
        prov_flag_r    <= prov_flag_nxt;
        prefer_prov_r  <= prefer_prov_nxt;
        manual_r       <= manual_nxt;
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_link_state          = out_state_r;
  assign out_radio_action        = out_action_r;
  assign out_listen_phase        = out_phase_r;
  assign out_manual_status       = out_manual_r;
  assign out_failed_attempts     = out_attempts_r;
  assign out_provisioned         = out_prov_r;
  assign out_persist_provisioned = out_persist_r;

endmodule

`default_nettype wire
